[rtl/sfd_pkg.sv]
// Shared types and constants of the SBUS frame decoder with mode gate.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int unsigned NUM_CH = 9;
  localparam int unsigned STORE_DEPTH = 24;
  localparam int unsigned LAST_POS = 24;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE_0 = 8'h00;
  localparam logic [7:0] END_BYTE_1 = 8'h04;
  localparam logic [7:0] END_BYTE_2 = 8'h14;
  localparam logic [7:0] END_BYTE_3 = 8'h24;
  localparam logic [7:0] END_BYTE_4 = 8'h34;

  localparam logic [10:0] RAW_MIN = 11'd172;
  localparam logic [20:0] SCALE = 21'd1000;
  localparam logic [21:0] RECIP = 22'd2620481;
  localparam logic [11:0] MAP_BASE = 12'd1000;
  localparam logic [11:0] CH_LO = 12'd800;
  localparam logic [11:0] CH_HI = 12'd2200;
  localparam logic [11:0] SEL_LO = 12'd1000;
  localparam logic [11:0] SEL_HI = 12'd2000;
  localparam logic [11:0] INV_BASE = 12'd3000;
  localparam logic [3:0] SEL_INDEX = 4'd8;

  localparam logic [3:0] PICK_ORDER [NUM_CH] = '{
    4'd2, 4'd0, 4'd4, 4'd5, 4'd10, 4'd11, 4'd6, 4'd7, 4'd8
  };

  localparam logic [2:0] CFG_EMERGENCY = 3'd0;
  localparam logic [2:0] CFG_AUTONOMOUS = 3'd1;
  localparam logic [2:0] CFG_RELAY_LOW = 3'd2;
  localparam logic [2:0] CFG_RELAY_HIGH = 3'd3;
  localparam logic [2:0] CFG_NEUTRAL = 3'd4;
  localparam logic [2:0] CFG_INVERT = 3'd5;

  typedef enum logic [2:0] {
    MODE_MANUAL     = 3'd0,
    MODE_EMERGENCY  = 3'd1,
    MODE_AUTO_NO_HB = 3'd2,
    MODE_AUTONOMOUS = 3'd3,
    MODE_AUTO_TMO   = 3'd4,
    MODE_RELAY      = 3'd5
  } mode_e;

  typedef struct packed {
    logic [11:0] estop_limit;
    logic [11:0] auto_limit;
    logic [11:0] relay_low;
    logic [11:0] relay_high;
    logic [11:0] neutral_value;
    logic [7:0]  invert_mask;
  } cfg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][10:0] raw;
    logic                    link_drop;
    logic                    failsafe;
    logic                    heartbeat_alive;
    logic                    command_fresh;
    logic [15:0]             auto_throttle;
    logic [15:0]             auto_steering;
  } desc_t;

endpackage

[rtl/sfd_front.sv]
// Front end: frame sync, byte store and raw channel extraction.
`timescale 1ns / 1ps

module sfd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               gap_reset_i,
  input  logic               heartbeat_alive_i,
  input  logic               command_fresh_i,
  input  logic [15:0]        auto_throttle_i,
  input  logic [15:0]        auto_steering_i,
  output logic               push_o,
  output sfd_pkg::desc_t     desc_o
);

  logic [4:0] pos_q, pos_d;
  logic [4:0] pos_eff;
  logic       take;
  logic       end_ok;
  logic [7:0] store_q [sfd_pkg::STORE_DEPTH];
  logic [8*(sfd_pkg::STORE_DEPTH-1)-1:0] stream;

  always_comb begin
    if (gap_reset_i || (pos_q >= 5'(sfd_pkg::LAST_POS + 1))) begin
      pos_eff = '0;
    end else begin
      pos_eff = pos_q;
    end
    take = accept_i && ((pos_eff != '0) || (rx_byte_i == sfd_pkg::START_BYTE));
    end_ok = (rx_byte_i == sfd_pkg::END_BYTE_0) || (rx_byte_i == sfd_pkg::END_BYTE_1) ||
             (rx_byte_i == sfd_pkg::END_BYTE_2) || (rx_byte_i == sfd_pkg::END_BYTE_3) ||
             (rx_byte_i == sfd_pkg::END_BYTE_4);
    pos_d = pos_q;
    if (accept_i) begin
      if (!take || (pos_eff == 5'(sfd_pkg::LAST_POS))) begin
        pos_d = '0;
      end else begin
        pos_d = pos_eff + 5'd1;
      end
    end
    push_o = take && (pos_eff == 5'(sfd_pkg::LAST_POS)) && end_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (pos_eff < 5'(sfd_pkg::STORE_DEPTH))) begin
      store_q[pos_eff] <= rx_byte_i;
    end
  end

  always_comb begin
    for (int j = 0; j < sfd_pkg::STORE_DEPTH - 1; j++) begin
      stream[8*j +: 8] = store_q[j+1];
    end
    for (int i = 0; i < sfd_pkg::NUM_CH; i++) begin
      desc_o.raw[i] = stream[11*int'(sfd_pkg::PICK_ORDER[i]) +: 11];
    end
    desc_o.link_drop       = store_q[sfd_pkg::STORE_DEPTH-1][2];
    desc_o.failsafe        = store_q[sfd_pkg::STORE_DEPTH-1][3];
    desc_o.heartbeat_alive = heartbeat_alive_i;
    desc_o.command_fresh   = command_fresh_i;
    desc_o.auto_throttle   = auto_throttle_i;
    desc_o.auto_steering   = auto_steering_i;
  end

endmodule

[rtl/sfd_queue.sv]
// Two-entry queue of decoded frames between the front and back ends.
`timescale 1ns / 1ps

module sfd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfd_pkg::desc_t din_i,
  input  logic           pop_i,
  output sfd_pkg::desc_t dout_o,
  output logic           valid_o,
  output logic           full_o
);

  sfd_pkg::desc_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, rd_q;
  logic       do_push, do_pop;

  always_comb begin
    do_push = push_i && (cnt_q != 2'd2);
    do_pop  = pop_i && (cnt_q != 2'd0);
    cnt_d   = cnt_q + 2'(do_push) - 2'(do_pop);
    valid_o = (cnt_q != 2'd0);
    full_o  = (cnt_q == 2'd2);
    dout_o  = mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= din_i;
    end
  end

endmodule

[rtl/sfd_back.sv]
// Back end: channel mapping pipeline, mode decision and result output.
`timescale 1ns / 1ps

module sfd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sfd_pkg::cfg_t  cfg_i,
  input  sfd_pkg::desc_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [3:0]     channel_index_o,
  output logic [11:0]    channel_value_o,
  output logic           last_o,
  output logic [2:0]     mode_o,
  output logic [15:0]    gated_throttle_o,
  output logic [15:0]    gated_steering_o,
  output logic           link_drop_o,
  output logic           failsafe_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CALC   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]  iss_q, iss_d;
  logic [3:0]  emit_q, emit_d;
  logic        issue;
  logic [10:0] raw;
  logic        neg;
  logic [10:0] mag;

  logic        p1_vld_q, p1_neg_q;
  logic [3:0]  p1_idx_q;
  logic [20:0] p1_n_q;
  logic        p2_vld_q, p2_neg_q;
  logic [3:0]  p2_idx_q;
  logic [10:0] p2_quo_q;
  logic [42:0] prod;
  logic [11:0] base, clamped, final_v;

  logic [11:0] val_q [sfd_pkg::NUM_CH];
  sfd_pkg::mode_e mode_q, mode_d;
  logic [15:0] gt_q, gt_d, gs_q, gs_d;

  logic        load;
  logic        ov_q;
  logic [3:0]  idx_q;
  logic [11:0] value_q;
  logic        last_q;
  logic [2:0]  omode_q;
  logic [15:0] ogt_q, ogs_q;
  logic        olost_q, ofs_q;

  always_comb begin
    raw   = head_i.raw[iss_q];
    neg   = raw < sfd_pkg::RAW_MIN;
    mag   = neg ? (sfd_pkg::RAW_MIN - raw) : (raw - sfd_pkg::RAW_MIN);
    prod  = 43'(p1_n_q) * 43'(sfd_pkg::RECIP);
    base  = p2_neg_q ? (sfd_pkg::MAP_BASE - 12'(p2_quo_q))
                     : (sfd_pkg::MAP_BASE + 12'(p2_quo_q));
    if (p2_idx_q == sfd_pkg::SEL_INDEX) begin
      if (base < sfd_pkg::SEL_LO) begin
        clamped = sfd_pkg::SEL_LO;
      end else if (base > sfd_pkg::SEL_HI) begin
        clamped = sfd_pkg::SEL_HI;
      end else begin
        clamped = base;
      end
      final_v = clamped;
    end else begin
      if (base < sfd_pkg::CH_LO) begin
        clamped = sfd_pkg::CH_LO;
      end else if (base > sfd_pkg::CH_HI) begin
        clamped = sfd_pkg::CH_HI;
      end else begin
        clamped = base;
      end
      final_v = cfg_i.invert_mask[p2_idx_q[2:0]] ? (sfd_pkg::INV_BASE - clamped) : clamped;
    end
  end

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    emit_d  = emit_q;
    issue   = 1'b0;
    load    = 1'b0;
    pop_o   = 1'b0;
    mode_d  = mode_q;
    gt_d    = gt_q;
    gs_d    = gs_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          iss_d   = '0;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (iss_q != 4'(sfd_pkg::NUM_CH)) begin
          issue = 1'b1;
          iss_d = iss_q + 4'd1;
        end else if (!p1_vld_q && !p2_vld_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (val_q[2] < cfg_i.estop_limit) begin
          mode_d = sfd_pkg::MODE_EMERGENCY;
          gt_d   = 16'(cfg_i.neutral_value);
          gs_d   = 16'(cfg_i.neutral_value);
        end else if (val_q[3] > cfg_i.auto_limit) begin
          if (!head_i.heartbeat_alive) begin
            mode_d = sfd_pkg::MODE_AUTO_NO_HB;
            gt_d   = 16'(cfg_i.neutral_value);
            gs_d   = 16'(cfg_i.neutral_value);
          end else if (head_i.command_fresh) begin
            mode_d = sfd_pkg::MODE_AUTONOMOUS;
            gt_d   = head_i.auto_throttle;
            gs_d   = head_i.auto_steering;
          end else begin
            mode_d = sfd_pkg::MODE_AUTO_TMO;
            gt_d   = 16'(cfg_i.neutral_value);
            gs_d   = 16'(cfg_i.neutral_value);
          end
        end else if ((val_q[8] > cfg_i.relay_low) && (val_q[8] <= cfg_i.relay_high)) begin
          mode_d = sfd_pkg::MODE_RELAY;
          gt_d   = 16'(cfg_i.neutral_value);
          gs_d   = 16'(cfg_i.neutral_value);
        end else begin
          mode_d = sfd_pkg::MODE_MANUAL;
          gt_d   = 16'(val_q[0]);
          gs_d   = 16'(val_q[1]);
        end
        emit_d  = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ov_q || !out_stall_i) begin
          load = 1'b1;
          if (emit_q == sfd_pkg::SEL_INDEX) begin
            pop_o   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            emit_d = emit_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      iss_q    <= '0;
      emit_q   <= '0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      emit_q   <= emit_d;
      p1_vld_q <= issue;
      p2_vld_q <= p1_vld_q;
      if (load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_neg_q <= neg;
    p1_idx_q <= iss_q;
    p1_n_q   <= 21'(mag) * sfd_pkg::SCALE;
    p2_neg_q <= p1_neg_q;
    p2_idx_q <= p1_idx_q;
    p2_quo_q <= prod[42:32];
    if (p2_vld_q) begin
      val_q[p2_idx_q] <= final_v;
    end
    mode_q <= mode_d;
    gt_q   <= gt_d;
    gs_q   <= gs_d;
    if (load) begin
      idx_q   <= emit_q;
      value_q <= val_q[emit_q];
      last_q  <= (emit_q == sfd_pkg::SEL_INDEX);
      omode_q <= mode_q;
      ogt_q   <= gt_q;
      ogs_q   <= gs_q;
      olost_q <= head_i.link_drop;
      ofs_q   <= head_i.failsafe;
    end
  end

  assign out_valid_o      = ov_q;
  assign channel_index_o  = idx_q;
  assign channel_value_o  = value_q;
  assign last_o           = last_q;
  assign mode_o           = omode_q;
  assign gated_throttle_o = ogt_q;
  assign gated_steering_o = ogs_q;
  assign link_drop_o      = olost_q;
  assign failsafe_o       = ofs_q;

`ifndef NO_ASSERTIONS
  a_calc_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> head_valid_i)
    else $error("Channel calculation runs without a queued frame.");

  a_pipe_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p2_vld_q |-> (state_q == ST_CALC))
    else $error("Mapping pipeline writes back outside the calculation phase.");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_stall_i && !last_q) |=> (ov_q && (idx_q == $past(idx_q) + 4'd1)))
    else $error("Result words of a frame are not delivered in index order.");
`endif

endmodule

[rtl/sbus_frame_decoder_mode_gate.sv]
// Top level of the SBUS frame decoder with mode gate and its register file.
`timescale 1ns / 1ps

// The block accepts one SBUS byte word per clock cycle and holds in_stall_o
// high only while its two-frame queue is full. Each frame with a valid start and end
// byte yields nine result words. The back end picks up a queued frame, issues its
// nine channels into a three-stage mapping pipeline (two multiplier stages and a
// clamp stage), waits until the last channel is written back, makes the mode
// decision and then emits the nine words, pausing while the output stalls.
// Configuration writes are always ready; the invert mask applies to frames whose
// calculation starts afterwards and the other registers to frames decided
// afterwards.
module sbus_frame_decoder_mode_gate (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        gap_reset_i,
  input  logic        heartbeat_alive_i,
  input  logic        command_fresh_i,
  input  logic [15:0] auto_throttle_i,
  input  logic [15:0] auto_steering_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  channel_index_o,
  output logic [11:0] channel_value_o,
  output logic        last_o,
  output logic [2:0]  mode_o,
  output logic [15:0] gated_throttle_o,
  output logic [15:0] gated_steering_o,
  output logic        link_drop_o,
  output logic        failsafe_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  sfd_pkg::cfg_t  cfg_q;
  sfd_pkg::desc_t front_desc, head_desc;
  logic front_push, head_valid, queue_full, back_pop, in_accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = queue_full;
  assign in_accept   = in_valid_i && !queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.estop_limit   <= 12'd1700;
      cfg_q.auto_limit    <= 12'd1700;
      cfg_q.relay_low     <= 12'd1250;
      cfg_q.relay_high    <= 12'd1750;
      cfg_q.neutral_value <= 12'd1500;
      cfg_q.invert_mask   <= 8'd206;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sfd_pkg::CFG_EMERGENCY:  cfg_q.estop_limit   <= cfg_data_i;
        sfd_pkg::CFG_AUTONOMOUS: cfg_q.auto_limit    <= cfg_data_i;
        sfd_pkg::CFG_RELAY_LOW:  cfg_q.relay_low     <= cfg_data_i;
        sfd_pkg::CFG_RELAY_HIGH: cfg_q.relay_high    <= cfg_data_i;
        sfd_pkg::CFG_NEUTRAL:    cfg_q.neutral_value <= cfg_data_i;
        sfd_pkg::CFG_INVERT:     cfg_q.invert_mask   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  sfd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .accept_i          (in_accept),
    .rx_byte_i         (rx_byte_i),
    .gap_reset_i       (gap_reset_i),
    .heartbeat_alive_i (heartbeat_alive_i),
    .command_fresh_i   (command_fresh_i),
    .auto_throttle_i   (auto_throttle_i),
    .auto_steering_i   (auto_steering_i),
    .push_o            (front_push),
    .desc_o            (front_desc)
  );

  sfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .din_i   (front_desc),
    .pop_i   (back_pop),
    .dout_o  (head_desc),
    .valid_o (head_valid),
    .full_o  (queue_full)
  );

  sfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_i           (head_desc),
    .head_valid_i     (head_valid),
    .pop_o            (back_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_index_o  (channel_index_o),
    .channel_value_o  (channel_value_o),
    .last_o           (last_o),
    .mode_o           (mode_o),
    .gated_throttle_o (gated_throttle_o),
    .gated_steering_o (gated_steering_o),
    .link_drop_o      (link_drop_o),
    .failsafe_o       (failsafe_o)
  );

endmodule

[tb/sv/sbus_frame_decoder_mode_gate_tb.sv]
// Self-checking testbench for the SBUS frame decoder with mode gate.
`timescale 1ns / 1ps

module sbus_frame_decoder_mode_gate_tb;

  localparam int unsigned FRAME_BYTES = 25;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned LIMIT_NS = 2_000_000;
  localparam logic [2:0] CFG_SPARE_6 = 3'd6;
  localparam logic [2:0] CFG_SPARE_7 = 3'd7;
  localparam logic [9:0][10:0] RAW_EDGES = {
    11'd0, 11'd171, 11'd172, 11'd173, 11'd991, 11'd992, 11'd1810, 11'd1811, 11'd1812, 11'd2047
  };

  typedef struct packed {
    logic [7:0]  rx;
    logic        gap;
    logic        hb;
    logic        fresh;
    logic [15:0] thr;
    logic [15:0] steer;
  } sbus_byte_t;

  typedef struct packed {
    logic [3:0]     index;
    logic [11:0]    value;
    logic           last;
    sfd_pkg::mode_e mode;
    logic [15:0]    thr;
    logic [15:0]    steer;
    logic           lost;
    logic           fs;
  } chan_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        gap_reset_i = 1'b0;
  logic        heartbeat_alive_i = 1'b0;
  logic        command_fresh_i = 1'b0;
  logic [15:0] auto_throttle_i = 16'h0000;
  logic [15:0] auto_steering_i = 16'h0000;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  channel_index_o;
  logic [11:0] channel_value_o;
  logic        last_o;
  logic [2:0]  mode_o;
  logic [15:0] gated_throttle_o;
  logic [15:0] gated_steering_o;
  logic        link_drop_o;
  logic        failsafe_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = 3'd0;
  logic [11:0] cfg_data_i = 12'd0;

  sbus_byte_t    byte_q [$];
  chan_word_t    chan_word_q [$];
  sbus_byte_t    on_wire;
  chan_word_t    exp_word;
  sfd_pkg::cfg_t shadow_cfg = '{12'd1700, 12'd1700, 12'd1250, 12'd1750, 12'd1500, 8'd206};
  logic [7:0]    frame_buf [FRAME_BYTES];
  int unsigned   frame_pos = 0;
  int unsigned   send_hold = 0;
  int unsigned   recv_hold = 0;
  bit            quiet = 1'b0;
  int unsigned   bytes_sent = 0;
  int unsigned   words_checked = 0;
  int unsigned   errors = 0;
  int unsigned   settings_used = 1;
  int unsigned   frames_in_mode [6] = '{default: 0};

  sbus_frame_decoder_mode_gate dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .rx_byte_i        (rx_byte_i),
    .gap_reset_i      (gap_reset_i),
    .heartbeat_alive_i(heartbeat_alive_i),
    .command_fresh_i  (command_fresh_i),
    .auto_throttle_i  (auto_throttle_i),
    .auto_steering_i  (auto_steering_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_index_o  (channel_index_o),
    .channel_value_o  (channel_value_o),
    .last_o           (last_o),
    .mode_o           (mode_o),
    .gated_throttle_o (gated_throttle_o),
    .gated_steering_o (gated_steering_o),
    .link_drop_o      (link_drop_o),
    .failsafe_o       (failsafe_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int scale_pulse(logic [10:0] raw);
    int offset;
    offset = int'(raw) - 172;
    return offset * 1000 / (1811 - 172) + 1000;
  endfunction

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [10:0] channel_bits(int unsigned k);
    logic [10:0] r;
    int unsigned p;
    for (int b = 0; b < 11; b++) begin
      p = k * 11 + b;
      r[b] = frame_buf[1 + p / 8][p % 8];
    end
    return r;
  endfunction

  task automatic decode_byte(input sbus_byte_t it);
    int             val [9];
    int unsigned    i;
    logic [7:0]     tail;
    sfd_pkg::mode_e m;
    logic [15:0]    gt;
    logic [15:0]    gs;
    chan_word_t     w;
    if (it.gap) frame_pos = 0;
    if (frame_pos >= FRAME_BYTES) frame_pos = 0;
    if (frame_pos == 0 && it.rx != sfd_pkg::START_BYTE) return;
    frame_buf[frame_pos] = it.rx;
    frame_pos++;
    if (frame_pos < FRAME_BYTES) return;
    frame_pos = 0;
    tail = frame_buf[24];
    if (tail != sfd_pkg::END_BYTE_0 && tail != sfd_pkg::END_BYTE_1 &&
        tail != sfd_pkg::END_BYTE_2 && tail != sfd_pkg::END_BYTE_3 &&
        tail != sfd_pkg::END_BYTE_4) return;
    for (i = 0; i < 9; i++) begin
      val[i] = scale_pulse(channel_bits(sfd_pkg::PICK_ORDER[i]));
      if (i < 8) begin
        val[i] = clamp_int(val[i], int'(sfd_pkg::CH_LO), int'(sfd_pkg::CH_HI));
        if (shadow_cfg.invert_mask[i]) val[i] = int'(sfd_pkg::INV_BASE) - val[i];
      end else begin
        val[i] = clamp_int(val[i], int'(sfd_pkg::SEL_LO), int'(sfd_pkg::SEL_HI));
      end
    end
    gt = 16'(shadow_cfg.neutral_value);
    gs = 16'(shadow_cfg.neutral_value);
    if (val[2] < int'(shadow_cfg.estop_limit)) begin
      m = sfd_pkg::MODE_EMERGENCY;
    end else if (val[3] > int'(shadow_cfg.auto_limit)) begin
      if (!it.hb) begin
        m = sfd_pkg::MODE_AUTO_NO_HB;
      end else if (it.fresh) begin
        m = sfd_pkg::MODE_AUTONOMOUS;
        gt = it.thr;
        gs = it.steer;
      end else begin
        m = sfd_pkg::MODE_AUTO_TMO;
      end
    end else if (val[8] > int'(shadow_cfg.relay_low) &&
                 val[8] <= int'(shadow_cfg.relay_high)) begin
      m = sfd_pkg::MODE_RELAY;
    end else begin
      m = sfd_pkg::MODE_MANUAL;
      gt = 16'(val[0]);
      gs = 16'(val[1]);
    end
    frames_in_mode[m]++;
    for (i = 0; i < 9; i++) begin
      w.index = 4'(i);
      w.value = 12'(val[i]);
      w.last = (i == 8);
      w.mode = m;
      w.thr = gt;
      w.steer = gs;
      w.lost = frame_buf[23][2];
      w.fs = frame_buf[23][3];
      chan_word_q.push_back(w);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        decode_byte(on_wire);
        bytes_sent++;
      end
      if (send_hold > 0) begin
        send_hold--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() > 0) begin
        on_wire = byte_q.pop_front();
        in_valid_i <= 1'b1;
        rx_byte_i <= on_wire.rx;
        gap_reset_i <= on_wire.gap;
        heartbeat_alive_i <= on_wire.hb;
        command_fresh_i <= on_wire.fresh;
        auto_throttle_i <= on_wire.thr;
        auto_steering_i <= on_wire.steer;
        if (!quiet && $urandom_range(0, 11) == 0) send_hold = $urandom_range(1, 12);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (chan_word_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got index %0d value %0d",
                   $time, channel_index_o, channel_value_o);
          errors++;
        end else begin
          exp_word = chan_word_q.pop_front();
          check_field("channel_index", 16'(exp_word.index), 16'(channel_index_o));
          check_field("channel_value", 16'(exp_word.value), 16'(channel_value_o));
          check_field("last", 16'(exp_word.last), 16'(last_o));
          check_field("mode", 16'(exp_word.mode), 16'(mode_o));
          check_field("gated_throttle", exp_word.thr, gated_throttle_o);
          check_field("gated_steering", exp_word.steer, gated_steering_o);
          check_field("link_drop", 16'(exp_word.lost), 16'(link_drop_o));
          check_field("failsafe", 16'(exp_word.fs), 16'(failsafe_o));
          words_checked++;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        recv_hold = $urandom_range(0, 11);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic sbus_byte_t filler(logic [7:0] rx, logic gap);
    sbus_byte_t it;
    it.rx = rx;
    it.gap = gap;
    it.hb = 1'($urandom);
    it.fresh = 1'($urandom);
    it.thr = 16'($urandom);
    it.steer = 16'($urandom);
    return it;
  endfunction

  function automatic logic [10:0] pick_raw();
    case ($urandom_range(0, 3))
      0: return 11'($urandom);
      1: return RAW_EDGES[$urandom_range(0, 9)];
      default: return 11'($urandom_range(172, 1811));
    endcase
  endfunction

  function automatic logic [7:0] pick_tail();
    case ($urandom_range(0, 5))
      0: return sfd_pkg::END_BYTE_0;
      1: return sfd_pkg::END_BYTE_1;
      2: return sfd_pkg::END_BYTE_2;
      3: return sfd_pkg::END_BYTE_3;
      4: return sfd_pkg::END_BYTE_4;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_pulse();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_frame(input logic [15:0][10:0] raw, input logic [7:0] flags,
                             input logic [7:0] tail, input logic resync, input logic hb,
                             input logic fresh, input logic [15:0] thr,
                             input logic [15:0] steer, input int unsigned keep);
    logic [175:0] flat;
    logic [7:0]   frame [FRAME_BYTES];
    sbus_byte_t   it;
    flat = raw;
    frame[0] = sfd_pkg::START_BYTE;
    for (int i = 1; i <= 22; i++) frame[i] = flat[(i - 1) * 8 +: 8];
    frame[23] = flags;
    frame[24] = tail;
    for (int i = 0; i < keep; i++) begin
      it = filler(frame[i], (i == 0) ? resync : 1'b0);
      if (i == FRAME_BYTES - 1) begin
        it.hb = hb;
        it.fresh = fresh;
        it.thr = thr;
        it.steer = steer;
      end
      byte_q.push_back(it);
    end
  endtask

  task automatic queue_random_frames(input int unsigned count);
    logic [15:0][10:0] raw;
    logic              resync;
    int unsigned       roll;
    repeat (count) begin
      roll = $urandom_range(0, 9);
      resync = 1'($urandom);
      if (roll == 0) begin
        repeat ($urandom_range(1, 4)) byte_q.push_back(filler(8'($urandom), 1'($urandom)));
        resync = 1'b1;
      end else if (roll == 1) begin
        for (int k = 0; k < 16; k++) raw[k] = pick_raw();
        queue_frame(raw, 8'($urandom), pick_tail(), resync, 1'b1, 1'b1, 16'h0, 16'h0,
                    $urandom_range(1, 24));
        resync = ($urandom_range(0, 3) != 0);
      end
      for (int k = 0; k < 16; k++) raw[k] = pick_raw();
      queue_frame(raw, 8'($urandom), pick_tail(), resync, ($urandom_range(0, 3) != 0),
                  1'($urandom), rand_pulse(), rand_pulse(), FRAME_BYTES);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [11:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      sfd_pkg::CFG_EMERGENCY:  shadow_cfg.estop_limit = data;
      sfd_pkg::CFG_AUTONOMOUS: shadow_cfg.auto_limit = data;
      sfd_pkg::CFG_RELAY_LOW:  shadow_cfg.relay_low = data;
      sfd_pkg::CFG_RELAY_HIGH: shadow_cfg.relay_high = data;
      sfd_pkg::CFG_NEUTRAL:    shadow_cfg.neutral_value = data;
      sfd_pkg::CFG_INVERT:     shadow_cfg.invert_mask = data[7:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic apply_settings(input logic [11:0] emergency, input logic [11:0] autonomous,
                                input logic [11:0] relay_lo, input logic [11:0] relay_hi,
                                input logic [11:0] neutral, input logic [7:0] mask);
    write_reg(sfd_pkg::CFG_EMERGENCY, emergency);
    write_reg(sfd_pkg::CFG_AUTONOMOUS, autonomous);
    write_reg(sfd_pkg::CFG_RELAY_LOW, relay_lo);
    write_reg(sfd_pkg::CFG_RELAY_HIGH, relay_hi);
    write_reg(sfd_pkg::CFG_NEUTRAL, neutral);
    write_reg(sfd_pkg::CFG_INVERT, {4'($urandom), mask});
    settings_used++;
  endtask

  task automatic settle();
    while (byte_q.size() != 0 || in_valid_i || chan_word_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0][10:0] raw;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes ahead of the first start byte must be dropped.
    byte_q.push_back(filler(8'h00, 1'b0));
    byte_q.push_back(filler(8'hFF, 1'b0));
    byte_q.push_back(filler(8'hF0, 1'b1));
    raw = {16{11'h7FF}};
    queue_frame(raw, 8'h0C, sfd_pkg::END_BYTE_0, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF,
                FRAME_BYTES);
    raw = '0;
    queue_frame(raw, 8'hF3, sfd_pkg::END_BYTE_1, 1'b0, 1'b0, 1'b1, 16'h0000, 16'h0000,
                FRAME_BYTES);
    raw = {16{11'd992}};
    raw[4] = 11'd172;
    raw[5] = 11'd172;
    queue_frame(raw, 8'h00, sfd_pkg::END_BYTE_2, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'h0000,
                FRAME_BYTES);
    queue_frame(raw, 8'h04, sfd_pkg::END_BYTE_3, 1'b0, 1'b1, 1'b0, 16'h0000, 16'hFFFF,
                FRAME_BYTES);
    raw[5] = 11'd1811;
    raw[8] = 11'd992;
    queue_frame(raw, 8'h08, sfd_pkg::END_BYTE_4, 1'b0, 1'b1, 1'b1, 16'h5A5A, 16'hA5A5,
                FRAME_BYTES);
    queue_frame(raw, 8'h00, 8'h05, 1'b0, 1'b1, 1'b1, 16'h1234, 16'h4321, FRAME_BYTES);
    queue_frame(raw, 8'h00, sfd_pkg::END_BYTE_0, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0000, 12);
    raw[8] = 11'd172;
    queue_frame(raw, 8'h0C, sfd_pkg::END_BYTE_0, 1'b1, 1'b1, 1'b0, 16'h00FF, 16'hFF00,
                FRAME_BYTES);
    raw[8] = 11'd2047;
    queue_frame(raw, 8'h00, sfd_pkg::END_BYTE_2, 1'b0, 1'b0, 1'b0, 16'hFF00, 16'h00FF,
                FRAME_BYTES);
    settle();

    apply_settings(12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095, 8'hFF);
    write_reg(CFG_SPARE_6, 12'($urandom));
    write_reg(CFG_SPARE_7, 12'($urandom));
    queue_random_frames(1);
    settle();

    apply_settings(12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 8'h00);
    queue_random_frames(1);
    settle();

    apply_settings(12'd4095, 12'($urandom), 12'd1000, 12'd4095, 12'($urandom), 8'($urandom));
    queue_random_frames(1);
    settle();

    apply_settings(12'($urandom_range(1200, 1800)), 12'($urandom_range(1200, 1800)),
                   12'($urandom_range(1000, 1500)), 12'($urandom_range(1500, 2000)),
                   12'($urandom), 8'($urandom));
    queue_random_frames(1);
    settle();

    quiet = 1'b1;
    apply_settings(12'd1700, 12'd1700, 12'd1250, 12'd1750, 12'd1500, 8'd206);
    queue_random_frames(1);
    settle();

    $display("Checked %0d channel words from %0d accepted bytes over %0d register settings.",
             words_checked, bytes_sent, settings_used);
    $display("Frames by mode: manual %0d, emergency %0d, no heartbeat %0d, autonomous %0d, %s",
             frames_in_mode[sfd_pkg::MODE_MANUAL], frames_in_mode[sfd_pkg::MODE_EMERGENCY],
             frames_in_mode[sfd_pkg::MODE_AUTO_NO_HB], frames_in_mode[sfd_pkg::MODE_AUTONOMOUS],
             $sformatf("timeout %0d, relay %0d", frames_in_mode[sfd_pkg::MODE_AUTO_TMO],
                       frames_in_mode[sfd_pkg::MODE_RELAY]));
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/sfd_pkg.sv
rtl/sfd_front.sv
rtl/sfd_queue.sv
rtl/sfd_back.sv
rtl/sbus_frame_decoder_mode_gate.sv
tb/sv/sbus_frame_decoder_mode_gate_tb.sv
